/* src/memory_range_table_builder_unit_assert.svh */
// Assertion macros for the memory range table builder.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef MEMORY_RANGE_TABLE_BUILDER_UNIT_ASSERT_SVH
`define MEMORY_RANGE_TABLE_BUILDER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MRTB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MRTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mrtb_pkg.sv */
// Shared types, codes and the firmware type translation for the range table builder.
// No dependencies.
package mrtb_pkg;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_RETYPE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_ROOM = 2'd1;
    localparam logic [1:0] STAT_BAD_IDX = 2'd2;

    localparam logic [2:0] REG_ENTRY_LIMIT = 3'd0;
    localparam logic [2:0] REG_KERNEL      = 3'd1;
    localparam logic [2:0] REG_BOOTINFO    = 3'd2;
    localparam logic [2:0] REG_PAGETABLE   = 3'd3;
    localparam logic [2:0] REG_ARCHIVE     = 3'd4;
    localparam logic [2:0] REG_HYP_STUB    = 3'd5;

    localparam logic [3:0] TY_USABLE     = 4'd0;
    localparam logic [3:0] TY_RESERVED   = 4'd1;
    localparam logic [3:0] TY_ACPI       = 4'd2;
    localparam logic [3:0] TY_NVS        = 4'd3;
    localparam logic [3:0] TY_BAD        = 4'd4;
    localparam logic [3:0] TY_LOADER     = 4'd5;
    localparam logic [3:0] TY_KERNEL     = 4'd6;
    localparam logic [3:0] TY_BOOTINFO   = 4'd7;
    localparam logic [3:0] TY_PAGETABLES = 4'd8;
    localparam logic [3:0] TY_FW_RUNTIME = 4'd9;
    localparam logic [3:0] TY_MMIO       = 4'd10;
    localparam logic [3:0] TY_PERSISTENT = 4'd11;
    localparam logic [3:0] TY_ARCHIVE    = 4'd12;
    localparam logic [3:0] TY_EL2        = 4'd13;

    typedef struct packed {
        logic [63:0] start;
        logic [63:0] size;
        logic [3:0]  kind;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_APP_CHK,
        ST_RD_WAIT,
        ST_RT_RD,
        ST_RT_CHK,
        ST_RT_EVAL,
        ST_RT_SH_RD,
        ST_RT_SH_WR,
        ST_RT_P0,
        ST_RT_P1,
        ST_RT_P2,
        ST_RESP
    } state_t;

    // Standard firmware types take precedence over the loader codes.
    function automatic logic [3:0] to_dense(
        input logic [31:0] t,
        input logic        runtime,
        input logic [31:0] kern,
        input logic [31:0] binfo,
        input logic [31:0] ptab,
        input logic [31:0] arch,
        input logic [31:0] hyp
    );
        logic [3:0] r;
        r = TY_RESERVED;
        if (runtime) begin
            r = TY_FW_RUNTIME;
        end else begin
            case (t)
                32'd7: r = TY_USABLE;
                32'd1, 32'd2, 32'd3, 32'd4: r = TY_LOADER;
                32'd5, 32'd6: r = TY_FW_RUNTIME;
                32'd9: r = TY_ACPI;
                32'd10: r = TY_NVS;
                32'd8: r = TY_BAD;
                32'd11, 32'd12: r = TY_MMIO;
                32'd14: r = TY_PERSISTENT;
                default: begin
                    if (t == kern) r = TY_KERNEL;
                    else if (t == binfo) r = TY_BOOTINFO;
                    else if (t == ptab) r = TY_PAGETABLES;
                    else if (t == arch) r = TY_ARCHIVE;
                    else if (t == hyp) r = TY_EL2;
                    else r = TY_RESERVED;
                end
            endcase
        end
        return r;
    endfunction

endpackage

/* src/mrtb_ram.sv */
// Single-port entry store with a registered read.
// Depends on mrtb_pkg (entry_t).
module mrtb_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   addr,
    input  mrtb_pkg::entry_t wdata,
    output mrtb_pkg::entry_t rdata
);
    mrtb_pkg::entry_t mem [DEPTH];
    mrtb_pkg::entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end else begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* src/memory_range_table_builder_unit.sv */
// Memory range table builder: top level, control sequencer and result register.
// Depends on mrtb_pkg, mrtb_ram and memory_range_table_builder_unit_assert.svh.
//
// Use: one item per s_ beat (s_tuser = kind), one result per item on the m_ side.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata; the user must
// write it only while idle, as the block does not enforce this. The table sits in a single-port RAM.
// A retype walks the table entry by entry; for each entry that it relabels it
// shifts the tail up to make room for the split pieces, and the walk stops
// for want of room.
// A new item is taken once the previous result sits in the output register,
// even if the receiver has not taken it yet; a stalled receiver holds the
// sequencer in its result state until the register frees.
// Reset (aresetn low, synchronous) empties the table, clears the failure flag
// and loads the register defaults; no clearing pass is needed.
`include "memory_range_table_builder_unit_assert.svh"

module memory_range_table_builder_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // fw_type, attributes, base_address, page_count, range_length, new_type,
    // entry_index
    input  logic [287:0] s_tdata,
    // kind
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, entry_count, map_failed, read_base, read_length, read_type
    output logic [143:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > 9) ? CW : 9;

    mrtb_pkg::state_t state_reg, state_next;

    logic [1:0]  kind_reg;
    logic [31:0] efi_reg;
    logic        runtime_reg;
    logic [63:0] base_reg, base_next;
    logic [51:0] pages_reg;
    logic [63:0] rlen_reg;
    logic [3:0]  ntype_reg;
    logic [7:0]  idx_reg;
    logic [63:0] end_reg, end_next;
    logic [3:0]  ty_reg, ty_next;

    logic [CW-1:0] count_reg, count_next;
    logic          failed_reg, failed_next;
    logic [8:0]    limit_reg;
    logic [31:0]   kern_reg, binfo_reg, ptab_reg, arch_reg, hyp_reg;

    logic [CW-1:0] i_reg, i_next, j_reg, j_next, wptr_reg, wptr_next;
    logic [63:0]   elo_reg, elo_next, ehi_reg, ehi_next;
    logic [3:0]    ekind_reg, ekind_next;
    logic [63:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic          lo_gt_reg, lo_gt_next, hi_lt_reg, hi_lt_next;

    logic [1:0]  res_status_reg, res_status_next;
    logic [63:0] res_base_reg, res_base_next, res_len_reg, res_len_next;
    logic [3:0]  res_type_reg, res_type_next;

    logic         m_valid_reg, m_valid_next;
    logic         load_out;
    logic [143:0] out_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    mrtb_pkg::entry_t mem_wdata, mem_rdata;

    logic          accept;
    logic [LW-1:0] eff_lim;
    logic [1:0]    extra;
    logic          ov_skip;
    logic [63:0]   ev_lo, ev_hi;

    mrtb_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
        .aclk  (aclk),
        .wr_en (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign s_tready = (state_reg == mrtb_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    assign eff_lim = (LW'(limit_reg) < LW'(TABLE_DEPTH)) ? LW'(limit_reg) : LW'(TABLE_DEPTH);
    assign extra   = {1'b0, lo_gt_reg} + {1'b0, hi_lt_reg};

    // Overlap test on the registered entry; wrapped ends are used as they are.
    assign ov_skip = (end_reg <= elo_reg) || (base_reg >= ehi_reg) || (ekind_reg == ntype_reg);
    assign ev_lo   = (base_reg > elo_reg) ? base_reg : elo_reg;
    assign ev_hi   = (end_reg < ehi_reg) ? end_reg : ehi_reg;

    always_comb begin
        logic [1:0] ev_extra;
        state_next      = state_reg;
        base_next       = base_reg;
        end_next        = end_reg;
        ty_next         = ty_reg;
        count_next      = count_reg;
        failed_next     = failed_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        wptr_next       = wptr_reg;
        elo_next        = elo_reg;
        ehi_next        = ehi_reg;
        ekind_next      = ekind_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        lo_gt_next      = lo_gt_reg;
        hi_lt_next      = hi_lt_reg;
        res_status_next = res_status_reg;
        res_base_next   = res_base_reg;
        res_len_next    = res_len_reg;
        res_type_next   = res_type_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        load_out        = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = '0;
        mem_wdata       = '0;
        ev_extra        = {1'b0, base_reg > elo_reg} + {1'b0, end_reg < ehi_reg};

        unique case (state_reg)
            mrtb_pkg::ST_IDLE: begin
                if (accept) begin
                    base_next  = s_tdata[159:96];
                    state_next = mrtb_pkg::ST_DECODE;
                end
            end
            mrtb_pkg::ST_DECODE: begin
                res_status_next = mrtb_pkg::STAT_OK;
                res_base_next   = '0;
                res_len_next    = '0;
                res_type_next   = '0;
                end_next        = base_reg + rlen_reg;
                ty_next = mrtb_pkg::to_dense(efi_reg, runtime_reg, kern_reg, binfo_reg,
                                             ptab_reg, arch_reg, hyp_reg);
                unique case (kind_reg)
                    mrtb_pkg::KIND_APPEND: begin
                        mem_addr = AW'(count_reg - CW'(1));
                        if (pages_reg == '0) state_next = mrtb_pkg::ST_RESP;
                        else state_next = mrtb_pkg::ST_APP_CHK;
                    end
                    mrtb_pkg::KIND_RETYPE: begin
                        i_next = '0;
                        if (rlen_reg == '0) state_next = mrtb_pkg::ST_RESP;
                        else state_next = mrtb_pkg::ST_RT_RD;
                    end
                    mrtb_pkg::KIND_READ: begin
                        mem_addr = AW'(idx_reg);
                        if (LW'(idx_reg) < LW'(count_reg)) begin
                            state_next = mrtb_pkg::ST_RD_WAIT;
                        end else begin
                            res_status_next = mrtb_pkg::STAT_BAD_IDX;
                            state_next      = mrtb_pkg::ST_RESP;
                        end
                    end
                    default: begin
                        count_next = '0;
                        state_next = mrtb_pkg::ST_RESP;
                    end
                endcase
            end
            mrtb_pkg::ST_APP_CHK: begin
                state_next = mrtb_pkg::ST_RESP;
                if (count_reg != '0 && mem_rdata.kind == ty_reg &&
                    mem_rdata.start + mem_rdata.size == base_reg) begin
                    mem_we          = 1'b1;
                    mem_addr        = AW'(count_reg - CW'(1));
                    mem_wdata.start = mem_rdata.start;
                    mem_wdata.size  = mem_rdata.size + {pages_reg, 12'h000};
                    mem_wdata.kind  = mem_rdata.kind;
                end else if (LW'(count_reg) >= eff_lim) begin
                    failed_next     = 1'b1;
                    res_status_next = mrtb_pkg::STAT_NO_ROOM;
                end else begin
                    mem_we          = 1'b1;
                    mem_addr        = AW'(count_reg);
                    mem_wdata.start = base_reg;
                    mem_wdata.size  = {pages_reg, 12'h000};
                    mem_wdata.kind  = ty_reg;
                    count_next      = count_reg + CW'(1);
                end
            end
            mrtb_pkg::ST_RD_WAIT: begin
                res_base_next = mem_rdata.start;
                res_len_next  = mem_rdata.size;
                res_type_next = mem_rdata.kind;
                state_next    = mrtb_pkg::ST_RESP;
            end
            mrtb_pkg::ST_RT_RD: begin
                if (i_reg >= count_reg) begin
                    state_next = mrtb_pkg::ST_RESP;
                end else begin
                    mem_addr   = AW'(i_reg);
                    state_next = mrtb_pkg::ST_RT_CHK;
                end
            end
            mrtb_pkg::ST_RT_CHK: begin
                elo_next   = mem_rdata.start;
                ehi_next   = mem_rdata.start + mem_rdata.size;
                ekind_next = mem_rdata.kind;
                state_next = mrtb_pkg::ST_RT_EVAL;
            end
            mrtb_pkg::ST_RT_EVAL: begin
                if (ov_skip) begin
                    i_next     = i_reg + CW'(1);
                    state_next = mrtb_pkg::ST_RT_RD;
                end else if ((LW + 1)'(count_reg) + (LW + 1)'(ev_extra) >
                             (LW + 1)'(eff_lim)) begin
                    res_status_next = mrtb_pkg::STAT_NO_ROOM;
                    state_next      = mrtb_pkg::ST_RESP;
                end else begin
                    lo_next    = ev_lo;
                    hi_next    = ev_hi;
                    lo_gt_next = base_reg > elo_reg;
                    hi_lt_next = end_reg < ehi_reg;
                    j_next     = count_reg;
                    state_next = mrtb_pkg::ST_RT_SH_RD;
                end
            end
            mrtb_pkg::ST_RT_SH_RD: begin
                // Move the tail up from the top down, reading each entry and then writing it.
                if ((CW + 1)'(j_reg) > (CW + 1)'(i_reg) + (CW + 1)'(1)) begin
                    mem_addr   = AW'(j_reg - CW'(1));
                    state_next = mrtb_pkg::ST_RT_SH_WR;
                end else begin
                    state_next = mrtb_pkg::ST_RT_P0;
                end
            end
            mrtb_pkg::ST_RT_SH_WR: begin
                mem_we     = 1'b1;
                mem_addr   = AW'(j_reg + CW'(extra) - CW'(1));
                mem_wdata  = mem_rdata;
                j_next     = j_reg - CW'(1);
                state_next = mrtb_pkg::ST_RT_SH_RD;
            end
            mrtb_pkg::ST_RT_P0: begin
                count_next = count_reg + CW'(extra);
                if (lo_gt_reg) begin
                    mem_we          = 1'b1;
                    mem_addr        = AW'(i_reg);
                    mem_wdata.start = elo_reg;
                    mem_wdata.size  = lo_reg - elo_reg;
                    mem_wdata.kind  = ekind_reg;
                    wptr_next       = i_reg + CW'(1);
                end else begin
                    wptr_next = i_reg;
                end
                state_next = mrtb_pkg::ST_RT_P1;
            end
            mrtb_pkg::ST_RT_P1: begin
                mem_we          = 1'b1;
                mem_addr        = AW'(wptr_reg);
                mem_wdata.start = lo_reg;
                mem_wdata.size  = hi_reg - lo_reg;
                mem_wdata.kind  = ntype_reg;
                wptr_next       = wptr_reg + CW'(1);
                state_next      = mrtb_pkg::ST_RT_P2;
            end
            mrtb_pkg::ST_RT_P2: begin
                // Walk resumes at the slot after the middle piece, right piece included.
                if (hi_lt_reg) begin
                    mem_we          = 1'b1;
                    mem_addr        = AW'(wptr_reg);
                    mem_wdata.start = hi_reg;
                    mem_wdata.size  = ehi_reg - hi_reg;
                    mem_wdata.kind  = ekind_reg;
                end
                i_next     = wptr_reg;
                state_next = mrtb_pkg::ST_RT_RD;
            end
            mrtb_pkg::ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = mrtb_pkg::ST_IDLE;
                end
            end
            default: state_next = mrtb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mrtb_pkg::ST_IDLE;
            count_reg   <= '0;
            failed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            limit_reg   <= 9'd256;
            kern_reg    <= 32'h8000_0000;
            binfo_reg   <= 32'h8000_0001;
            ptab_reg    <= 32'h8000_0002;
            arch_reg    <= 32'h8000_0003;
            hyp_reg     <= 32'h8000_0004;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            failed_reg  <= failed_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    mrtb_pkg::REG_ENTRY_LIMIT: limit_reg <= cfg_wdata[8:0];
                    mrtb_pkg::REG_KERNEL:      kern_reg  <= cfg_wdata;
                    mrtb_pkg::REG_BOOTINFO:    binfo_reg <= cfg_wdata;
                    mrtb_pkg::REG_PAGETABLE:   ptab_reg  <= cfg_wdata;
                    mrtb_pkg::REG_ARCHIVE:     arch_reg  <= cfg_wdata;
                    mrtb_pkg::REG_HYP_STUB:    hyp_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg    <= s_tuser;
            efi_reg     <= s_tdata[31:0];
            runtime_reg <= s_tdata[95];
            pages_reg   <= s_tdata[211:160];
            rlen_reg    <= s_tdata[275:212];
            ntype_reg   <= s_tdata[279:276];
            idx_reg     <= s_tdata[287:280];
        end
        base_reg       <= base_next;
        end_reg        <= end_next;
        ty_reg         <= ty_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        wptr_reg       <= wptr_next;
        elo_reg        <= elo_next;
        ehi_reg        <= ehi_next;
        ekind_reg      <= ekind_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        lo_gt_reg      <= lo_gt_next;
        hi_lt_reg      <= hi_lt_next;
        res_status_reg <= res_status_next;
        res_base_reg   <= res_base_next;
        res_len_reg    <= res_len_next;
        res_type_reg   <= res_type_next;
        if (load_out) begin
            out_reg <= {res_type_reg, res_len_reg, res_base_reg, failed_reg,
                        9'(count_reg), res_status_reg};
        end
    end

    `MRTB_ASSERT_NOW(a_count_in_range, 1'b1, (CW + 1)'(count_reg) <= (CW + 1)'(TABLE_DEPTH), "entry count beyond table depth")
    `MRTB_ASSERT_NOW(a_failed_sticky, 1'b1, !$fell(failed_reg), "failure flag dropped without reset")
    `MRTB_ASSERT_NEXT(a_accept_busy, accept, state_reg == mrtb_pkg::ST_DECODE, "accepted beat not decoded")
    `MRTB_ASSERT_NOW(a_no_write_idle, state_reg == mrtb_pkg::ST_IDLE || state_reg == mrtb_pkg::ST_RESP, !mem_we, "table written outside an item")
endmodule

/* test/testbench.sv */
// Self-checking testbench for memory_range_table_builder_unit.
// Needs mrtb_pkg and the unit's RTL; drives items as stream beats and predicts each result.
module testbench;

    localparam int DEPTH = 256;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] efi;
        logic [63:0] attr;
        logic [63:0] base;
        logic [51:0] pages;
        logic [63:0] rlen;
        logic [3:0]  ntype;
        logic [7:0]  idx;
    } req_t;

    typedef struct {
        logic [1:0]  status;
        logic [8:0]  count;
        logic        failed;
        logic [63:0] rbase;
        logic [63:0] rlength;
        logic [3:0]  rtype;
    } resp_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic [1:0]   s_tuser = mrtb_pkg::KIND_APPEND;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_addr = mrtb_pkg::REG_ENTRY_LIMIT;
    logic [31:0]  cfg_wdata = '0;

    memory_range_table_builder_unit #(.TABLE_DEPTH(DEPTH)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // shadow of the table and registers
    logic [63:0] tbl_start [DEPTH];
    logic [63:0] tbl_size  [DEPTH];
    logic [3:0]  tbl_kind  [DEPTH];
    int unsigned tbl_count;
    logic        tbl_failed;
    int unsigned limit_reg;
    logic [31:0] kern_code, binfo_code, ptab_code, arch_code, hyp_code;

    resp_t expected_q[$];
    int    mismatches = 0;
    int    items_sent = 0;
    int    results_seen = 0;
    int    no_room_seen = 0;
    int    splits_seen = 0;
    bit    idle_en = 1'b1;
    logic [63:0] next_addr;

    function automatic int unsigned room_limit();
        return limit_reg < DEPTH ? limit_reg : DEPTH;
    endfunction

    // runtime bit beats everything; standard types beat loader codes
    function automatic logic [3:0] dense_type(logic [31:0] t, logic [63:0] attr);
        if (attr[63]) return mrtb_pkg::TY_FW_RUNTIME;
        case (t)
            32'd7: return mrtb_pkg::TY_USABLE;
            32'd1, 32'd2, 32'd3, 32'd4: return mrtb_pkg::TY_LOADER;
            32'd5, 32'd6: return mrtb_pkg::TY_FW_RUNTIME;
            32'd9: return mrtb_pkg::TY_ACPI;
            32'd10: return mrtb_pkg::TY_NVS;
            32'd8: return mrtb_pkg::TY_BAD;
            32'd11, 32'd12: return mrtb_pkg::TY_MMIO;
            32'd14: return mrtb_pkg::TY_PERSISTENT;
            default: ;
        endcase
        if (t == kern_code) return mrtb_pkg::TY_KERNEL;
        if (t == binfo_code) return mrtb_pkg::TY_BOOTINFO;
        if (t == ptab_code) return mrtb_pkg::TY_PAGETABLES;
        if (t == arch_code) return mrtb_pkg::TY_ARCHIVE;
        if (t == hyp_code) return mrtb_pkg::TY_EL2;
        return mrtb_pkg::TY_RESERVED;
    endfunction

    function automatic logic [1:0] table_append(logic [31:0] t, logic [63:0] attr,
                                                logic [63:0] base, logic [51:0] pages);
        logic [63:0] len;
        logic [3:0]  ty;
        int unsigned last;
        if (pages == 0) return mrtb_pkg::STAT_OK;
        len = {pages, 12'h000};
        ty = dense_type(t, attr);
        if (tbl_count > 0) begin
            last = tbl_count - 1;
            if (tbl_kind[last] == ty && tbl_start[last] + tbl_size[last] == base) begin
                tbl_size[last] = tbl_size[last] + len;
                return mrtb_pkg::STAT_OK;
            end
        end
        if (tbl_count >= room_limit()) begin
            tbl_failed = 1'b1;
            return mrtb_pkg::STAT_NO_ROOM;
        end
        tbl_start[tbl_count] = base;
        tbl_size[tbl_count] = len;
        tbl_kind[tbl_count] = ty;
        tbl_count++;
        return mrtb_pkg::STAT_OK;
    endfunction

    function automatic logic [1:0] table_retype(logic [63:0] base, logic [63:0] len,
                                                logic [3:0] ty);
        logic [63:0] fin, elo, ehi, lo, hi;
        logic [3:0]  old;
        int unsigned extra, i, j, k;
        if (len == 0) return mrtb_pkg::STAT_OK;
        fin = base + len;
        i = 0;
        while (i < tbl_count) begin
            elo = tbl_start[i];
            ehi = elo + tbl_size[i];
            if (fin <= elo || base >= ehi || tbl_kind[i] == ty) begin
                i++;
                continue;
            end
            lo = base > elo ? base : elo;
            hi = fin < ehi ? fin : ehi;
            old = tbl_kind[i];
            extra = (lo > elo ? 1 : 0) + (hi < ehi ? 1 : 0);
            if (tbl_count + extra > room_limit()) return mrtb_pkg::STAT_NO_ROOM;
            if (extra > 0) splits_seen++;
            for (j = tbl_count; j > i + 1; j--) begin
                tbl_start[j - 1 + extra] = tbl_start[j - 1];
                tbl_size[j - 1 + extra] = tbl_size[j - 1];
                tbl_kind[j - 1 + extra] = tbl_kind[j - 1];
            end
            tbl_count += extra;
            k = i;
            if (lo > elo) begin
                tbl_start[k] = elo;
                tbl_size[k] = lo - elo;
                tbl_kind[k] = old;
                k++;
            end
            tbl_start[k] = lo;
            tbl_size[k] = hi - lo;
            tbl_kind[k] = ty;
            k++;
            if (hi < ehi) begin
                tbl_start[k] = hi;
                tbl_size[k] = ehi - hi;
                tbl_kind[k] = old;
            end
            i = k;
        end
        return mrtb_pkg::STAT_OK;
    endfunction

    function automatic resp_t predict_result(req_t r);
        resp_t e;
        e = '{default: '0};
        case (r.op)
            mrtb_pkg::KIND_APPEND: e.status = table_append(r.efi, r.attr, r.base, r.pages);
            mrtb_pkg::KIND_RETYPE: e.status = table_retype(r.base, r.rlen, r.ntype);
            mrtb_pkg::KIND_READ: begin
                if (r.idx < tbl_count) begin
                    e.rbase = tbl_start[r.idx];
                    e.rlength = tbl_size[r.idx];
                    e.rtype = tbl_kind[r.idx];
                end else begin
                    e.status = mrtb_pkg::STAT_BAD_IDX;
                end
            end
            default: tbl_count = 0;
        endcase
        e.count = tbl_count[8:0];
        e.failed = tbl_failed;
        return e;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("mismatch on result %0d: %s got 0x%0h, want 0x%0h",
                 results_seen, field, got, want);
    endtask

    // result checker
    always @(posedge aclk) begin
        resp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], 64'h0);
            end else begin
                e = expected_q.pop_front();
                if (m_tdata[1:0] != e.status) report_mismatch("status", m_tdata[1:0], e.status);
                if (m_tdata[10:2] != e.count) report_mismatch("entry_count", m_tdata[10:2], e.count);
                if (m_tdata[11] != e.failed) report_mismatch("map_failed", m_tdata[11], e.failed);
                if (m_tdata[75:12] != e.rbase) report_mismatch("read_base", m_tdata[75:12], e.rbase);
                if (m_tdata[139:76] != e.rlength)
                    report_mismatch("read_length", m_tdata[139:76], e.rlength);
                if (m_tdata[143:140] != e.rtype)
                    report_mismatch("read_type", m_tdata[143:140], e.rtype);
                if (e.status == mrtb_pkg::STAT_NO_ROOM) no_room_seen++;
            end
            results_seen++;
        end
    end

    // receiver back-pressure in bursts
    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(req_t r);
        int gap;
        gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.op;
        s_tdata <= {r.idx, r.ntype, r.rlen, r.pages, r.base, r.attr, r.efi};
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(predict_result(r));
        items_sent++;
    endtask

    // lowers valid, then waits for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        drain();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            mrtb_pkg::REG_ENTRY_LIMIT: limit_reg = value[8:0];
            mrtb_pkg::REG_KERNEL:      kern_code = value;
            mrtb_pkg::REG_BOOTINFO:    binfo_code = value;
            mrtb_pkg::REG_PAGETABLE:   ptab_code = value;
            mrtb_pkg::REG_ARCHIVE:     arch_code = value;
            default:                   hyp_code = value;
        endcase
    endtask

    function automatic req_t blank_req(logic [1:0] op);
        req_t r;
        r = '{default: '0};
        r.op = op;
        return r;
    endfunction

    task automatic do_append(logic [31:0] efi, logic [63:0] attr, logic [63:0] base,
                             logic [51:0] pages);
        req_t r;
        r = blank_req(mrtb_pkg::KIND_APPEND);
        r.efi = efi; r.attr = attr; r.base = base; r.pages = pages;
        send_item(r);
    endtask

    task automatic do_retype(logic [63:0] base, logic [63:0] len, logic [3:0] ty);
        req_t r;
        r = blank_req(mrtb_pkg::KIND_RETYPE);
        r.base = base; r.rlen = len; r.ntype = ty;
        send_item(r);
    endtask

    task automatic do_read(logic [7:0] idx);
        req_t r;
        r = blank_req(mrtb_pkg::KIND_READ);
        r.idx = idx;
        send_item(r);
    endtask

    task automatic do_clear();
        send_item(blank_req(mrtb_pkg::KIND_CLEAR));
    endtask

    task automatic test_translation();
        do_append(32'd7, 64'h0, 64'h1000, 52'd0);           // zero pages
        do_append(32'd7, 64'h0, 64'h1000, 52'd4);
        do_append(32'd7, 64'h0, 64'h5000, 52'd2);           // merges
        do_append(32'd7, 64'h8000_0000_0000_0000, 64'h7000, 52'd1);
        do_append(32'd1, 64'h0, 64'h10000, 52'd1);
        do_append(32'd5, 64'h0, 64'h20000, 52'd1);
        do_append(32'd9, 64'h0, 64'h30000, 52'd1);
        do_append(32'd10, 64'h0, 64'h40000, 52'd1);
        do_append(32'd8, 64'h0, 64'h50000, 52'd1);
        do_append(32'd12, 64'h0, 64'h60000, 52'd1);
        do_append(32'd14, 64'h0, 64'h70000, 52'd1);
        do_append(32'h8000_0000, 64'h0, 64'h80000, 52'd1);
        do_append(32'h8000_0001, 64'h0, 64'h90000, 52'd1);
        do_append(32'h8000_0002, 64'h0, 64'hA0000, 52'd1);
        do_append(32'h8000_0003, 64'h0, 64'hB0000, 52'd1);
        do_append(32'h8000_0004, 64'h0, 64'hC0000, 52'd1);
        do_append(32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'hD0000, 52'hF_FFFF_FFFF_FFFF);
        do_read(8'd0);
        do_read(8'd16);
        do_read(8'd255);                                    // beyond count
    endtask

    task automatic test_retype_cases();
        do_retype(64'h2000, 64'h1000, mrtb_pkg::TY_BAD);    // three-way split
        do_retype(64'h0, 64'h0, mrtb_pkg::TY_EL2);          // zero length
        do_retype(64'h7000, 64'h11000, 4'd15);              // spans several entries
        do_retype(64'hFFFF_FFFF_FFFF_F000, 64'h2000, 4'd14); // end wraps
        do_read(8'd1);
        do_read(8'd2);
        do_read(8'd3);
        // loader codes that collide with standard types or with each other
        write_reg(mrtb_pkg::REG_KERNEL, 32'd7);
        write_reg(mrtb_pkg::REG_BOOTINFO, 32'd7);
        write_reg(mrtb_pkg::REG_PAGETABLE, 32'h55);
        write_reg(mrtb_pkg::REG_ARCHIVE, 32'h55);
        write_reg(mrtb_pkg::REG_HYP_STUB, 32'hFFFF_FFFF);
        do_clear();
        do_append(32'd7, 64'h0, 64'h0, 52'd1);
        do_append(32'h55, 64'h0, 64'h1000, 52'd1);
        do_append(32'hFFFF_FFFF, 64'h0, 64'h2000, 52'd1);
        // a low limit: split stops part-way, append fails, clear keeps the flag
        write_reg(mrtb_pkg::REG_ENTRY_LIMIT, 32'd4);
        do_retype(64'h0, 64'h3000, mrtb_pkg::TY_USABLE);
        do_retype(64'h800, 64'h1000, mrtb_pkg::TY_MMIO);
        do_append(32'd3, 64'h0, 64'h9000, 52'd1);
        do_append(32'd3, 64'h0, 64'hA000, 52'd1);
        write_reg(mrtb_pkg::REG_ENTRY_LIMIT, 32'd1);
        do_append(32'd7, 64'h0, 64'h20000, 52'd1);          // limit below count
        do_clear();
        do_read(8'd0);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] pick_efi();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return kern_code;
            2: return binfo_code;
            3: return $urandom_range(0, 1) ? arch_code : hyp_code;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    task automatic random_noise();
        req_t r;
        r.op = 2'($urandom_range(0, 3));
        r.efi = $urandom;
        r.attr = rand64();
        r.base = rand64();
        r.pages = 52'(rand64());
        r.rlen = rand64();
        r.ntype = 4'($urandom_range(0, 15));
        r.idx = 8'($urandom_range(0, 255));
        if (r.op == mrtb_pkg::KIND_CLEAR && $urandom_range(0, 3) != 0)
            r.op = mrtb_pkg::KIND_READ;
        send_item(r);
    endtask

    // one table built from mostly contiguous descriptors, then relabelled and read back
    task automatic random_frame();
        int n;
        logic [63:0] b;
        do_clear();
        next_addr = {36'h0, 8'($urandom_range(0, 255)), 20'h0};
        n = $urandom_range(2, 14);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) next_addr += $urandom_range(1, 8) << 12;
            b = next_addr;
            do_append(pick_efi(), $urandom_range(0, 7) == 0 ? rand64() : 64'h0,
                      b, 52'($urandom_range(0, 8)));
            next_addr = tbl_count > 0 ? tbl_start[tbl_count - 1] + tbl_size[tbl_count - 1]
                                      : next_addr;
        end
        repeat ($urandom_range(1, 5)) begin
            b = tbl_count > 0 ? tbl_start[$urandom_range(0, tbl_count - 1)] : next_addr;
            b += $urandom_range(0, 3) == 0 ? $urandom_range(0, 'h3FFF) :
                 ($urandom_range(0, 7) << 12);
            do_retype(b, $urandom_range(0, 7) == 0 ? 64'h0 : 64'($urandom_range(1, 'h12000)),
                      4'($urandom_range(0, 15)));
        end
        repeat ($urandom_range(1, 4)) do_read(8'($urandom_range(0, tbl_count + 2)));
        if ($urandom_range(0, 2) == 0) random_noise();
    endtask

    task automatic random_settings();
        case ($urandom_range(0, 5))
            0: write_reg(mrtb_pkg::REG_ENTRY_LIMIT, 32'd256);
            1: write_reg(mrtb_pkg::REG_ENTRY_LIMIT, $urandom_range(1, 12));
            2: write_reg(mrtb_pkg::REG_ENTRY_LIMIT, $urandom_range(1, 256));
            3: write_reg(mrtb_pkg::REG_KERNEL,
                         $urandom_range(0, 1) ? $urandom : $urandom_range(0, 15));
            4: write_reg(mrtb_pkg::REG_ARCHIVE, $urandom);
            default: write_reg(mrtb_pkg::REG_PAGETABLE,
                               $urandom_range(0, 1) ? kern_code : $urandom);
        endcase
    endtask

    task automatic test_random();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (items_sent - start > RANDOM_ITEMS - 250) idle_en = 1'b0;
            if ($urandom_range(0, 9) == 0) random_settings();
            if ($urandom_range(0, 7) == 0) random_noise();
            else random_frame();
        end
    endtask

    initial begin
        limit_reg = 256;
        kern_code = 32'h8000_0000;
        binfo_code = 32'h8000_0001;
        ptab_code = 32'h8000_0002;
        arch_code = 32'h8000_0003;
        hyp_code = 32'h8000_0004;
        tbl_count = 0;
        tbl_failed = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_translation();
        test_retype_cases();
        write_reg(mrtb_pkg::REG_ENTRY_LIMIT, 32'd256);
        test_random();
        drain();
        repeat (50) @(posedge aclk);
        $display("%0d items sent, %0d results checked, %0d no-room results, %0d splits",
                 items_sent, results_seen, no_room_seen, splits_seen);
        $display("covered appends, merges, retype splits and limits, reads and clears");
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* memory_range_table_builder_unit.f */
+incdir+src
src/mrtb_pkg.sv
src/mrtb_ram.sv
src/memory_range_table_builder_unit.sv
test/testbench.sv
